FILE: sv/sacm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacm_pkg
// Shared types and constants of the set-associative cache hit/miss model.
// ----------------------------------------------------------------------------
package sacm_pkg;

	localparam int ADDR_W        = 31;
	localparam int STAMP_W       = 32;
	localparam int WAY_W         = 6;
	localparam int LG_W          = 3;
	localparam int MAX_WAYS_LOG2 = 6;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;

	// register index, taken from paddr[2]
	localparam logic REG_WAYS_LOG2 = 1'b0;
	localparam logic REG_POLICY    = 1'b1;

	// replacement policy codes
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_LIFO = 2'd1;
	localparam logic [1:0] POL_LRU  = 2'd2;
	localparam logic [1:0] POL_MRU  = 2'd3;

	// one tag store line
	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  block;
		logic [STAMP_W-1:0] fill_stamp;
		logic [STAMP_W-1:0] use_stamp;
	} entry_t;

endpackage : sacm_pkg
`default_nettype wire

FILE: sv/sacm_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacm_rem
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module sacm_rem #(
	parameter int DIVIDEND_W = 28,
	parameter int REM_W      = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [REM_W-1:0]      divisor,
	output logic                       done,
	output logic [REM_W-1:0]           rem
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [REM_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;

	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic [REM_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[DIVIDEND_W-1]};
		diff    = trial - {1'b0, divisor};
		// partial remainder stays below the divisor
		rem_nxt = (trial >= {1'b0, divisor}) ? diff[REM_W-1:0] : trial[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIVIDEND_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= quo_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule : sacm_rem
`default_nettype wire

FILE: sv/sacm_tag_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sacm_tag_ram
// Tag and stamp store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sacm_tag_ram
	import sacm_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire entry_t           wdata,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : sacm_tag_ram
`default_nettype wire

FILE: sv/set_assoc_cache_hit_miss_model_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss_model_core
// Set-associative tag store model with FIFO/LIFO/LRU/MRU replacement.
//
//   channel | signals                               | beat
//   --------+---------------------------------------+----------------------
//   in      | in_valid in_ready address             | one byte address
//   out     | out_valid out_ready hit way evicted   | one lookup result
//           | miss_total                            |
//   apb     | psel penable pwrite paddr pwdata      | ways_log2 @0x0,
//           | prdata pready                         | replace_policy @0x4
//
// Timing: a beat runs from accept through the bit-serial set-index remainder
//   over the BLK_W = 31 - OFFSET_BITS block bits and the one-way-per-cycle walk
//   of the set through the RAM and its write-back before the next is accepted.
// Reset: after arst_n releases, a clearing pass zeroes every one of the LINES
//   lines; in_ready stays low meanwhile, APB writes are taken throughout.
// Stalls: a finished result sits in the output register; the next address is
//   accepted and worked on, and only the write-back waits for out_ready.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_miss_model_core
	import sacm_pkg::*;
#(
	parameter int LINES       = 64,
	parameter int OFFSET_BITS = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// address beats
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [ADDR_W-1:0]  address,
	// result beats
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic [WAY_W-1:0]        way,
	output logic                    evicted,
	output logic [STAMP_W-1:0]      miss_total,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	// ------------------------------------------------------------------
	// Derived sizes
	// ------------------------------------------------------------------
	localparam int BLK_W    = ADDR_W - OFFSET_BITS;
	localparam int IDX_W    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int REM_W    = $clog2(LINES + 1);
	localparam int FLOOR_LG = $clog2(LINES + 1) - 1;
	// ways per set can never exceed LINES nor 64
	localparam int CAP_LG   = (FLOOR_LG < MAX_WAYS_LOG2) ? FLOOR_LG : MAX_WAYS_LOG2;
	localparam int BASE_W   = REM_W + MAX_WAYS_LOG2;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_WB    = 5'b10000
	} state_t;

	state_t state_q;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [LG_W-1:0] ways_log2_q;
	logic [1:0]      policy_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_log2_q <= '0;
			policy_q    <= POL_FIFO;
		end else if (cfg_wr) begin
			unique case (paddr[PADDR_W-1])
				REG_WAYS_LOG2: ways_log2_q <= pwdata[LG_W-1:0];
				REG_POLICY:    policy_q    <= pwdata[1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[PADDR_W-1])
			REG_WAYS_LOG2: prdata = {{(PDATA_W-LG_W){1'b0}}, ways_log2_q};
			REG_POLICY:    prdata = {{(PDATA_W-2){1'b0}}, policy_q};
			default:       prdata = '0;
		endcase
	end

	// Set geometry from the clamped way count
	logic [LG_W-1:0]  eff_lg;
	logic [WAY_W-1:0] ways_m1;
	logic [REM_W-1:0] sets;
	logic             want_old;
	logic             by_fill;

	always_comb begin
		eff_lg   = (ways_log2_q > LG_W'(CAP_LG)) ? LG_W'(CAP_LG) : ways_log2_q;
		ways_m1  = WAY_W'((7'd1 << eff_lg) - 7'd1);
		sets     = REM_W'(LINES) >> eff_lg;
		want_old = (policy_q == POL_FIFO) || (policy_q == POL_LRU);
		by_fill  = (policy_q == POL_FIFO) || (policy_q == POL_LIFO);
	end

	// ------------------------------------------------------------------
	// Set index: block mod sets
	// ------------------------------------------------------------------
	logic [BLK_W-1:0] block_q;
	logic             in_fire;
	logic             rem_done;
	logic [REM_W-1:0] set_idx;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			block_q <= address[ADDR_W-1:OFFSET_BITS];
		end
	end

	sacm_rem #(
		.DIVIDEND_W (BLK_W),
		.REM_W      (REM_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.dividend (address[ADDR_W-1:OFFSET_BITS]),
		.divisor  (sets),
		.done     (rem_done),
		.rem      (set_idx)
	);

	// ------------------------------------------------------------------
	// Line addressing: base of the set plus way
	// ------------------------------------------------------------------
	logic [WAY_W-1:0]  rd_way_q;
	logic [WAY_W-1:0]  fin_way;
	logic [WAY_W-1:0]  line_way;
	logic [BASE_W-1:0] base_wide;
	logic [BASE_W-1:0] line_wide;
	logic [IDX_W-1:0]  line_idx;

	always_comb begin
		line_way  = (state_q == ST_WB) ? fin_way : rd_way_q;
		base_wide = {{MAX_WAYS_LOG2{1'b0}}, set_idx} << eff_lg;
		line_wide = base_wide + {{REM_W{1'b0}}, line_way};
		line_idx  = line_wide[IDX_W-1:0];
	end

	// ------------------------------------------------------------------
	// Tag RAM
	// ------------------------------------------------------------------
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	entry_t           mem_rdata;

	sacm_tag_ram #(
		.DEPTH (LINES),
		.IDX_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.wr_en (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rd_en (mem_re),
		.raddr (line_idx),
		.rdata (mem_rdata)
	);

	// ------------------------------------------------------------------
	// Set walk: one way read per cycle, evaluated in the next cycle from registered RAM data
	// ------------------------------------------------------------------
	logic               issue_done_q;
	logic               eval_vld_s1;
	logic [WAY_W-1:0]   eval_way_s1;
	logic               hit_found_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic [STAMP_W-1:0] hit_fill_q;
	logic               empty_found_q;
	logic [WAY_W-1:0]   empty_way_q;
	logic [STAMP_W-1:0] best_age_q;
	logic [WAY_W-1:0]   best_way_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] miss_counter_q;

	logic               is_hit;
	logic [STAMP_W-1:0] age;
	logic               better;
	logic               scan_last;

	assign mem_re = (state_q == ST_SCAN) && !issue_done_q;

	always_comb begin
		is_hit = mem_rdata.valid && (mem_rdata.block == ADDR_W'(block_q));
		// age survives clock wrap
		age    = now_q - (by_fill ? mem_rdata.fill_stamp : mem_rdata.use_stamp);
		// lowest way wins ties
		better = (eval_way_s1 == '0) ||
		         (want_old ? (age > best_age_q) : (age < best_age_q));
		scan_last = eval_vld_s1 && (eval_way_s1 == ways_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_vld_s1 <= 1'b0;
		end else begin
			eval_vld_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		eval_way_s1 <= rd_way_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_done_q  <= 1'b0;
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			rd_way_q      <= '0;
		end else if (state_q == ST_DIV && rem_done) begin
			issue_done_q  <= 1'b0;
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			rd_way_q      <= '0;
		end else if (state_q == ST_SCAN) begin
			if (mem_re) begin
				issue_done_q <= (rd_way_q == ways_m1);
				rd_way_q     <= rd_way_q + WAY_W'(1);
			end
			if (eval_vld_s1) begin
				if (is_hit && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (!mem_rdata.valid && !empty_found_q) begin
					empty_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && eval_vld_s1) begin
			if (is_hit && !hit_found_q) begin
				hit_way_q  <= eval_way_s1;
				hit_fill_q <= mem_rdata.fill_stamp;
			end
			if (!mem_rdata.valid && !empty_found_q) begin
				empty_way_q <= eval_way_s1;
			end
			if (better) begin
				best_age_q <= age;
				best_way_q <= eval_way_s1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Write-back and result
	// ------------------------------------------------------------------
	logic               wb_go;
	logic               fin_evict;
	logic [IDX_W-1:0]   clr_idx_q;
	logic               out_valid_q;
	logic               hit_q;
	logic [WAY_W-1:0]   way_q;
	logic               evicted_q;

	assign wb_go = (state_q == ST_WB) && (!out_valid_q || out_ready);

	always_comb begin
		fin_evict = 1'b0;
		priority if (hit_found_q) begin
			fin_way = hit_way_q;
		end else if (empty_found_q) begin
			fin_way = empty_way_q;
		end else begin
			fin_way   = best_way_q;
			fin_evict = 1'b1;
		end
	end

	always_comb begin
		mem_wdata.valid      = 1'b1;
		mem_wdata.block      = ADDR_W'(block_q);
		mem_wdata.fill_stamp = hit_found_q ? hit_fill_q : now_q;
		mem_wdata.use_stamp  = now_q;
		mem_we               = wb_go;
		mem_waddr            = line_idx;
		if (state_q == ST_CLEAR) begin
			mem_wdata = '0;
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q          <= '0;
			miss_counter_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (wb_go) begin
				now_q       <= now_q + STAMP_W'(1);
				out_valid_q <= 1'b1;
				if (!hit_found_q && (miss_counter_q != '1)) begin
					miss_counter_q <= miss_counter_q + STAMP_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			hit_q     <= hit_found_q;
			way_q     <= fin_way;
			evicted_q <= fin_evict;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign way        = way_q;
	assign evicted    = evicted_q;
	assign miss_total = miss_counter_q;

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	a_hit_never_evicts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> !evicted)
		else $error("hit result flagged as eviction");

	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_go && hit_found_q) |=> $stable(miss_counter_q))
		else $error("miss counter moved on a hit");

	a_rem_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == ST_DIV))
		else $error("set index finished outside the index phase");

	a_ram_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_WB) || (state_q == ST_CLEAR)))
		else $error("tag RAM written outside write-back or clear");
`endif

endmodule : set_assoc_cache_hit_miss_model_core
`default_nettype wire
